@@ design/mjdf_pkg.sv @@
`default_nettype none

package mjdf_pkg;

    localparam int unsigned KEY_LEN = 16;

    localparam logic [7:0] BYTE_MARK   = 8'hFF;
    localparam logic [7:0] BYTE_SOI    = 8'hD8;
    localparam logic [7:0] BYTE_EOI    = 8'hD9;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_KEY_C = 8'h43;

    localparam logic [15:0] TAIL_EOI = {BYTE_MARK, BYTE_EOI};

    // Register index decoded from the word address
    localparam logic REG_MAX_FRAMES = 1'b0;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_last;
        logic        frame_ok;
        logic [15:0] frames_done;
    } result_t;

    // Characters of "Content-Length: "
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            4'd14:   c = 8'h3A;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    // Advance a pointer of the three-entry result queue
    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

endpackage

`default_nettype wire

@@ design/mjpeg_multipart_deframer.sv @@
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-------------------------------------------
// s_        | in        | s_valid / s_ready  | s_in_byte (one stream byte per word)
// m_        | out       | m_valid / m_ready  | m_out_byte, m_frame_last, m_frame_ok,
//           |           |                    | m_frames_done
// apb       | in/out    | psel/penable/pready| max_frames at byte address 0
//
// Every accepted word is decoded in the cycle it arrives; its results (none, one,
// or two on a start-of-image marker) go into a three-entry result queue.
// One word per cycle is sustained while m_ready stays high; only the two-result start of a
// frame holds the input back, since s_ready drops while two or more results wait.
// aresetn is synchronous and active low; it clears all parser state, the frame
// count and the queue, and sets max_frames to 65535.
// A stall on m_ready fills the queue and then holds s_ready low; nothing is lost.
module mjpeg_multipart_deframer #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_frame_last,
    output logic             m_frame_ok,
    output logic [15:0]      m_frames_done,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mjdf_pkg::*;

    localparam int unsigned    ACC_BITS = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [15:0] max_frames_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_FRAMES);
    assign prdata    = (paddr[2] == REG_MAX_FRAMES) ? {16'd0, max_frames_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frames_reg <= 16'hFFFF;
        end else if (cfg_write) begin
            max_frames_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [7:0]             prev_byte_reg,   prev_byte_next;
    logic                   prev_valid_reg,  prev_valid_next;
    logic                   inside_reg,      inside_next;
    logic [LENGTH_BITS-1:0] emitted_reg,     emitted_next;
    logic [LENGTH_BITS-1:0] frame_len_reg,   frame_len_next;
    logic [LENGTH_BITS-1:0] acc_reg,         acc_next;
    logic [4:0]             key_pos_reg,     key_pos_next;
    logic                   digits_reg,      digits_next;
    logic [15:0]            tail_reg,        tail_next;
    logic [15:0]            good_cnt_reg,    good_cnt_next;

    // Result queue
    result_t    q_mem [3];
    logic [1:0] q_head_reg, q_head_next;
    logic [1:0] q_tail_reg, q_tail_next;
    logic [1:0] q_cnt_reg,  q_cnt_next;

    logic          in_fire;
    logic          out_fire;
    logic          limit_hit;
    logic [1:0]    push_cnt;
    result_t       res0;
    result_t       res1;

    // Frame byte helpers
    logic [LENGTH_BITS-1:0] emitted_inc;
    logic [15:0]            tail_shift;
    logic                   frame_end;
    logic                   tail_good;

    // Header helpers
    logic                   is_digit;
    logic [ACC_BITS-1:0]    acc_times10;
    logic                   key_hit;
    logic                   marker_seen;

    assign s_ready  = !q_cnt_reg[1];
    assign m_valid  = (q_cnt_reg != 2'd0);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    assign limit_hit = (good_cnt_reg >= max_frames_reg);

    assign emitted_inc = emitted_reg + LEN_ONE;
    assign tail_shift  = {tail_reg[7:0], s_in_byte};
    assign frame_end   = (emitted_inc >= frame_len_reg);
    assign tail_good   = (tail_shift == TAIL_EOI);

    assign is_digit    = (s_in_byte >= ASCII_ZERO) && (s_in_byte <= ASCII_NINE);
    // acc * 10 + digit, as two shifts and two adds
    assign acc_times10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                       + ACC_BITS'(s_in_byte[3:0]);
    assign key_hit     = !key_pos_reg[4] && (s_in_byte == key_char(key_pos_reg[3:0]));
    assign marker_seen = prev_valid_reg && (prev_byte_reg == BYTE_MARK)
                      && (s_in_byte == BYTE_SOI) && (frame_len_reg >= LEN_TWO);

    always_comb begin
        prev_byte_next  = prev_byte_reg;
        prev_valid_next = prev_valid_reg;
        inside_next     = inside_reg;
        emitted_next    = emitted_reg;
        frame_len_next  = frame_len_reg;
        acc_next        = acc_reg;
        key_pos_next    = key_pos_reg;
        digits_next     = digits_reg;
        tail_next       = tail_reg;
        good_cnt_next   = good_cnt_reg;
        push_cnt        = 2'd0;
        res0            = '{out_byte: s_in_byte, frame_last: 1'b0, frame_ok: 1'b0,
                            frames_done: good_cnt_reg};
        res1            = '{out_byte: BYTE_SOI, frame_last: 1'b0, frame_ok: 1'b0,
                            frames_done: good_cnt_reg};

        if (in_fire && !limit_hit) begin
            if (inside_reg) begin
                // Pass a frame byte on; close the frame at the declared length
                push_cnt  = 2'd1;
                tail_next = tail_shift;
                if (frame_end) begin
                    if (tail_good) begin
                        good_cnt_next = good_cnt_reg + 16'd1;
                    end
                    res0.frame_last  = 1'b1;
                    res0.frame_ok    = tail_good;
                    res0.frames_done = tail_good ? good_cnt_reg + 16'd1 : good_cnt_reg;
                    inside_next      = 1'b0;
                    prev_valid_next  = 1'b0;
                    emitted_next     = '0;
                end else begin
                    emitted_next = emitted_inc;
                end
            end else if (marker_seen) begin
                // Start of image: emit FF and D8; a length of two ends here
                push_cnt       = 2'd2;
                res0.out_byte  = BYTE_MARK;
                key_pos_next   = 5'd0;
                digits_next    = 1'b0;
                acc_next       = '0;
                tail_next      = {BYTE_MARK, BYTE_SOI};
                if (frame_len_reg == LEN_TWO) begin
                    res1.frame_last = 1'b1;
                    prev_valid_next = 1'b0;
                    emitted_next    = '0;
                end else begin
                    inside_next  = 1'b1;
                    emitted_next = LEN_TWO;
                end
            end else begin
                prev_byte_next  = s_in_byte;
                prev_valid_next = 1'b1;
                if (digits_reg && is_digit) begin
                    // Accumulate, saturating at the largest length
                    acc_next = (acc_times10 > {4'd0, LEN_MAX})
                             ? LEN_MAX : acc_times10[LENGTH_BITS-1:0];
                end else begin
                    if (digits_reg) begin
                        frame_len_next = acc_reg;
                        digits_next    = 1'b0;
                    end
                    // Key match, restarting from the first character
                    if (key_hit && (!digits_reg || key_pos_reg == 5'd0)) begin
                        if (key_pos_reg == 5'(KEY_LEN - 1)) begin
                            key_pos_next = 5'd0;
                            digits_next  = 1'b1;
                            acc_next     = '0;
                        end else begin
                            key_pos_next = key_pos_reg + 5'd1;
                        end
                    end else begin
                        key_pos_next = (s_in_byte == ASCII_KEY_C) ? 5'd1 : 5'd0;
                    end
                end
            end
        end

        q_tail_next = q_tail_reg;
        if (push_cnt == 2'd1) begin
            q_tail_next = inc3(q_tail_reg);
        end else if (push_cnt == 2'd2) begin
            q_tail_next = inc3(inc3(q_tail_reg));
        end
        q_head_next = out_fire ? inc3(q_head_reg) : q_head_reg;
        q_cnt_next  = q_cnt_reg + push_cnt - {1'b0, out_fire};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
            inside_reg     <= 1'b0;
            emitted_reg    <= '0;
            frame_len_reg  <= '0;
            acc_reg        <= '0;
            key_pos_reg    <= '0;
            digits_reg     <= 1'b0;
            tail_reg       <= '0;
            good_cnt_reg   <= '0;
            q_head_reg     <= '0;
            q_tail_reg     <= '0;
            q_cnt_reg      <= '0;
        end else begin
            prev_byte_reg  <= prev_byte_next;
            prev_valid_reg <= prev_valid_next;
            inside_reg     <= inside_next;
            emitted_reg    <= emitted_next;
            frame_len_reg  <= frame_len_next;
            acc_reg        <= acc_next;
            key_pos_reg    <= key_pos_next;
            digits_reg     <= digits_next;
            tail_reg       <= tail_next;
            good_cnt_reg   <= good_cnt_next;
            q_head_reg     <= q_head_next;
            q_tail_reg     <= q_tail_next;
            q_cnt_reg      <= q_cnt_next;
        end
    end

    // Queue storage: write the new results behind the tail
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_mem[q_tail_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            q_mem[inc3(q_tail_reg)] <= res1;
        end
    end

    assign m_out_byte    = q_mem[q_head_reg].out_byte;
    assign m_frame_last  = q_mem[q_head_reg].frame_last;
    assign m_frame_ok    = q_mem[q_head_reg].frame_ok;
    assign m_frames_done = q_mem[q_head_reg].frames_done;

endmodule

`default_nettype wire
